// File: hdl/lzss_bitstream_decompressor_defines.svh
// Assertion macros used by the decompressor command queue
`ifndef LZSS_BITSTREAM_DECOMPRESSOR_DEFINES_SVH
`define LZSS_BITSTREAM_DECOMPRESSOR_DEFINES_SVH

// checked only outside reset
`define LBD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lbd assertion failed");

// checked on every edge, reset included
`define LBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lbd assertion failed");

`endif

// File: hdl/lbd_pkg.sv
// Shared constants and types of the LZSS decompressor
package lbd_pkg;
    localparam int WINDOW_BITS = 13;
    localparam int LENGTH_BITS = 4;
    localparam int MATCH_BITS  = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int LIT_BITS    = 9;
    localparam int MAX_OUTPUT  = 65536;
    localparam int CNT_W       = 17;
    localparam int BUF_W       = MATCH_BITS + 7;
    localparam int BCNT_W      = 5;
    localparam int FIFO_DEPTH  = 4;
    localparam int FPTR_W      = 2;
    localparam int FCNT_W      = 3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CSIZE = 3'd1;
    localparam logic [2:0] ST_BAD_OSIZE = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_NO_END    = 3'd4;
    localparam logic [2:0] ST_BAD_DIST  = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    localparam logic [1:0] CMD_LIT   = 2'd0;
    localparam logic [1:0] CMD_MATCH = 2'd1;
    localparam logic [1:0] CMD_STAT  = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [7:0]             lit;
        logic [WINDOW_BITS-1:0] pos;
        logic [LENGTH_BITS-1:0] len;
        logic [CNT_W-1:0]       count;
        logic [2:0]             status;
        logic                   last;
    } t_cmd;
endpackage

// File: hdl/lbd_stream_ifs.sv
// Input and output channel interfaces of the decompressor
interface lbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_end;
    modport source (output valid, in_byte, frame_end, input ready);
    modport sink (input valid, in_byte, frame_end, output ready);
endinterface

interface lbd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data;
    logic [16:0] out_count;
    logic [2:0]  status;
    logic        last;
    modport source (output valid, kind, data, out_count, status, last, input ready);
    modport sink (input valid, kind, data, out_count, status, last, output ready);
endinterface

// File: hdl/lzss_bitstream_decompressor.sv
// Top level of the LZSS frame decompressor
//  channel   | dir | payload                                   | beat when
//  i_in_ch   | in  | in_byte[7:0], frame_end                   | valid && ready
//  o_out_ch  | out | kind, data[7:0], out_count[16:0],         | valid && ready
//            |     | status[2:0], last                         |
// A byte is accepted in F_IDLE and decoded in F_DEC, token by token for a token byte;
// the last byte of a frame then passes through F_STAT to queue the status beat.
// The copy engine pops a match, then per copied byte reads history (B_RD),
// then writes and outputs it (B_CP); literals and status beats pop directly.
// A 4-deep command queue lets the front end run ahead of the copy engine.
// Reset (i_rst_n low, synchronous) clears control state; history needs none.
// Back-pressure on o_out_ch stalls the copy engine, then fills the queue.
module lzss_bitstream_decompressor import lbd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbd_in_if.sink    i_in_ch,
    lbd_out_if.source o_out_ch
);
    t_cmd push_cmd, pop_cmd;
    logic push, pop, full, empty;

    lbd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in_ch),
        .o_cmd(push_cmd), .o_push(push), .i_full(full)
    );

    lbd_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(push_cmd),
        .i_pop(pop), .o_cmd(pop_cmd), .o_full(full), .o_empty(empty)
    );

    lbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(pop_cmd), .i_empty(empty),
        .o_pop(pop), .o_out(o_out_ch)
    );
endmodule

// File: hdl/lbd_front.sv
// Front end: header varints, bit buffer, token decode and checks
module lbd_front import lbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbd_in_if.sink     i_in,
    output t_cmd       o_cmd,
    output logic       o_push,
    input  logic       i_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DEC  = 2'd1;
    localparam logic [1:0] F_STAT = 2'd2;

    localparam logic [1:0] PH_CSIZE  = 2'd0;
    localparam logic [1:0] PH_OSIZE  = 2'd1;
    localparam logic [1:0] PH_TOKENS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [31:0]       r_vval, n_vval;
    logic [5:0]        r_vsh, n_vsh;
    logic [31:0]       r_csize, n_csize;
    logic [CNT_W-1:0]  r_osize, n_osize;
    logic [CNT_W-1:0]  r_prod, n_prod;
    logic [31:0]       r_fbc, n_fbc;
    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [BCNT_W-1:0] r_bcnt, n_bcnt;
    logic [2:0]        r_err, n_err;
    logic              r_end, n_end;
    logic              r_fend, n_fend;
    logic              r_pv, n_pv;
    t_cmd              r_pend, n_pend;

    // a chunk of up to 2^7 shifted by 28 reaches bit 35
    logic [35:0]       v_sum;
    logic              v_ovf;
    logic [BUF_W-1:0]  sh_flag, sh_lit, sh_m;
    logic              flag;
    logic              tok_ok;
    logic [LENGTH_BITS-1:0] m_len;
    logic [WINDOW_BITS-1:0] m_pos;
    logic [CNT_W:0]    m_sum;
    logic [CNT_W:0]    m_dist;
    logic [4:0]        m_cnt;
    logic              would_emit;
    t_cmd              c;
    logic [2:0]        st;

    always_comb begin
        v_sum = {4'b0, r_vval} + (36'({1'b0, i_in.in_byte[6:0]} + 8'd1) << r_vsh);
        v_ovf = (r_vsh >= 6'd32) || (v_sum[35:32] != 4'd0);
        sh_flag = r_buf >> (r_bcnt - 5'd1);
        sh_lit  = r_buf >> (r_bcnt - 5'(LIT_BITS));
        sh_m    = r_buf >> (r_bcnt - 5'(MATCH_BITS));
        flag    = sh_flag[0];
        m_len   = sh_m[LENGTH_BITS-1:0];
        m_pos   = sh_m[LENGTH_BITS +: WINDOW_BITS];
        m_cnt   = 5'(m_len) + 5'd2;
        m_sum   = {1'b0, r_prod} + (CNT_W+1)'(m_cnt);
        m_dist  = (CNT_W+1)'(m_pos) + 1'b1;
        tok_ok  = (r_phase == PH_TOKENS) && (r_err == ST_OK) && (r_bcnt != '0) &&
                  (flag ? (r_bcnt >= 5'(MATCH_BITS)) : (r_bcnt >= 5'(LIT_BITS)));
        if (r_err != ST_OK)                     st = r_err;
        else if (r_phase == PH_CSIZE || r_phase == PH_OSIZE) st = ST_TRUNC;
        else if (r_csize > r_fbc)               st = ST_BAD_CSIZE;
        else if (!r_end)                        st = ST_TRUNC;
        else                                    st = ST_OK;
    end

    always_comb begin
        n_state = r_state; n_phase = r_phase; n_vval = r_vval; n_vsh = r_vsh;
        n_csize = r_csize; n_osize = r_osize; n_prod = r_prod; n_fbc = r_fbc;
        n_buf = r_buf; n_bcnt = r_bcnt; n_err = r_err; n_end = r_end;
        n_fend = r_fend; n_pv = r_pv; n_pend = r_pend;
        o_push = 1'b0;
        o_cmd = r_pend;
        o_cmd.last = 1'b0;
        i_in.ready = (r_state == F_IDLE);
        c = '0;
        would_emit = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_in.valid) begin
                    if (r_fbc != 32'hffff_ffff) n_fbc = r_fbc + 32'd1;
                    n_fend = i_in.frame_end;
                    n_state = F_DEC;
                    if (r_err == ST_OK) begin
                        if (r_phase == PH_CSIZE || r_phase == PH_OSIZE) begin
                            if (v_ovf) begin
                                n_err = (r_phase == PH_CSIZE) ? ST_BAD_CSIZE : ST_BAD_OSIZE;
                            end else if (i_in.in_byte[7]) begin
                                n_vval = v_sum[31:0];
                                n_vsh = r_vsh + 6'd7;
                            end else begin
                                n_vval = '0;
                                n_vsh = '0;
                                if (r_phase == PH_CSIZE) begin
                                    n_csize = v_sum[31:0];
                                    n_phase = PH_OSIZE;
                                end else if (v_sum[31:0] == 32'd0 ||
                                             v_sum[31:0] > 32'(MAX_OUTPUT)) begin
                                    n_err = ST_BAD_OSIZE;
                                end else begin
                                    n_osize = v_sum[CNT_W-1:0];
                                    n_phase = PH_TOKENS;
                                end
                            end
                        end else if (r_phase == PH_TOKENS) begin
                            n_buf = {r_buf[BUF_W-9:0], i_in.in_byte};
                            n_bcnt = r_bcnt + 5'd8;
                        end
                    end
                end
            end
            F_DEC: begin
                if (tok_ok) begin
                    n_bcnt = r_bcnt - (flag ? 5'(MATCH_BITS) : 5'(LIT_BITS));
                    n_buf = r_buf & ((BUF_W'(1) << n_bcnt) - BUF_W'(1));
                    if (!flag) begin
                        if (r_prod >= r_osize) n_err = ST_NO_END;
                        else begin
                            would_emit = 1'b1;
                            c.op = CMD_LIT;
                            c.lit = sh_lit[7:0];
                            n_prod = r_prod + 1'b1;
                        end
                    end else if (m_pos == '1 && m_len == '1) begin
                        n_end = 1'b1;
                        n_phase = PH_DONE;
                    end else if (r_prod >= r_osize) begin
                        n_err = ST_NO_END;
                    end else if (m_sum > {1'b0, r_osize}) begin
                        n_err = ST_OVERRUN;
                    end else if (m_dist > {1'b0, r_prod}) begin
                        n_err = ST_BAD_DIST;
                    end else begin
                        would_emit = 1'b1;
                        c.op = CMD_MATCH;
                        c.pos = m_pos;
                        c.len = m_len;
                        n_prod = m_sum[CNT_W-1:0];
                    end
                    if (would_emit) begin
                        if (r_pv && i_full) begin
                            // queue full: hold everything and retry
                            n_bcnt = r_bcnt; n_buf = r_buf; n_prod = r_prod;
                        end else begin
                            o_push = r_pv;
                            n_pend = c;
                            n_pv = 1'b1;
                        end
                    end
                end else if (!(r_pv && i_full)) begin
                    o_push = r_pv;
                    o_cmd.last = !r_fend;
                    n_pv = 1'b0;
                    n_state = r_fend ? F_STAT : F_IDLE;
                end
            end
            F_STAT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    o_cmd = '0;
                    o_cmd.op = CMD_STAT;
                    o_cmd.count = r_prod;
                    o_cmd.status = st;
                    o_cmd.last = 1'b1;
                    n_state = F_IDLE;
                    n_phase = PH_CSIZE; n_vval = '0; n_vsh = '0; n_csize = '0;
                    n_osize = '0; n_prod = '0; n_fbc = '0; n_buf = '0; n_bcnt = '0;
                    n_err = ST_OK; n_end = 1'b0;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE; r_phase <= PH_CSIZE; r_vval <= '0; r_vsh <= '0;
            r_csize <= '0; r_osize <= '0; r_prod <= '0; r_fbc <= '0;
            r_buf <= '0; r_bcnt <= '0; r_err <= ST_OK; r_end <= 1'b0;
            r_fend <= 1'b0; r_pv <= 1'b0;
        end else begin
            r_state <= n_state; r_phase <= n_phase; r_vval <= n_vval; r_vsh <= n_vsh;
            r_csize <= n_csize; r_osize <= n_osize; r_prod <= n_prod; r_fbc <= n_fbc;
            r_buf <= n_buf; r_bcnt <= n_bcnt; r_err <= n_err; r_end <= n_end;
            r_fend <= n_fend; r_pv <= n_pv;
        end
        r_pend <= n_pend;
    end
endmodule

// File: hdl/lbd_fifo.sv
// Command queue between front end and copy engine
`include "lzss_bitstream_decompressor_defines.svh"
module lbd_fifo import lbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);
    t_cmd              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wp, r_rp;
    logic [FCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + FCNT_W'(i_push) - FCNT_W'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    `LBD_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `LBD_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty)
    `LBD_ASSERT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 3'd1))
    `LBD_ASSERT_ALWAYS(a_count_range, i_clk, !i_rst_n || (r_cnt <= FCNT_W'(FIFO_DEPTH)))
endmodule

// File: hdl/lbd_back.sv
// Copy engine: history window, match copies and the output register
module lbd_back import lbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  logic     i_empty,
    output logic     o_pop,
    lbd_out_if.source o_out
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_CP   = 2'd2;

    logic [7:0]             r_hist [2**WINDOW_BITS];
    logic [1:0]             r_st, n_st;
    logic [WINDOW_BITS-1:0] r_wptr, n_wptr;
    logic [WINDOW_BITS-1:0] r_pos, n_pos;
    logic [4:0]             r_rem, n_rem;
    logic                   r_last, n_last;
    logic [7:0]             r_rd;
    logic                   r_ov, n_ov;
    logic                   r_kind, n_kind;
    logic [7:0]             r_data, n_data;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [2:0]             r_stat, n_stat;
    logic                   r_olast, n_olast;
    logic                   we;
    logic [7:0]             wd;
    logic                   out_free;

    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_st = r_st; n_wptr = r_wptr; n_pos = r_pos; n_rem = r_rem; n_last = r_last;
        n_ov = r_ov && !o_out.ready;
        n_kind = r_kind; n_data = r_data; n_cnt = r_cnt; n_stat = r_stat;
        n_olast = r_olast;
        we = 1'b0; wd = i_cmd.lit; o_pop = 1'b0;
        unique case (r_st)
            B_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_LIT: begin
                            we = 1'b1;
                            n_wptr = r_wptr + 1'b1;
                            n_ov = 1'b1; n_kind = 1'b0; n_data = i_cmd.lit;
                            n_cnt = '0; n_stat = ST_OK; n_olast = i_cmd.last;
                        end
                        CMD_STAT: begin
                            n_wptr = '0;
                            n_ov = 1'b1; n_kind = 1'b1; n_data = '0;
                            n_cnt = i_cmd.count; n_stat = i_cmd.status; n_olast = i_cmd.last;
                        end
                        default: begin
                            n_pos = i_cmd.pos;
                            n_rem = 5'(i_cmd.len) + 5'd2;
                            n_last = i_cmd.last;
                            n_st = B_RD;
                        end
                    endcase
                end
            end
            B_RD: n_st = B_CP;
            B_CP: begin
                if (out_free) begin
                    we = 1'b1; wd = r_rd;
                    n_wptr = r_wptr + 1'b1;
                    n_rem = r_rem - 5'd1;
                    n_ov = 1'b1; n_kind = 1'b0; n_data = r_rd;
                    n_cnt = '0; n_stat = ST_OK;
                    n_olast = r_last && (r_rem == 5'd1);
                    n_st = (r_rem == 5'd1) ? B_IDLE : B_RD;
                end
            end
            default: n_st = B_IDLE;
        endcase
    end

    // overlapping copies: each byte is written before the next one is read
    always_ff @(posedge i_clk) begin
        if (we) r_hist[r_wptr] <= wd;
        if (r_st == B_RD) r_rd <= r_hist[r_wptr - r_pos - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE; r_wptr <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_wptr <= n_wptr; r_ov <= n_ov;
        end
        r_pos <= n_pos; r_rem <= n_rem; r_last <= n_last;
        r_kind <= n_kind; r_data <= n_data; r_cnt <= n_cnt;
        r_stat <= n_stat; r_olast <= n_olast;
    end

    assign o_out.valid     = r_ov;
    assign o_out.kind      = r_kind;
    assign o_out.data      = r_data;
    assign o_out.out_count = r_cnt;
    assign o_out.status    = r_stat;
    assign o_out.last      = r_olast;
endmodule
